// ===== rtl/core/dpod_pkg.sv =====
package dpod_pkg;

  localparam int YEAR_W     = 14;
  localparam int MONTH_W    = 4;
  localparam int DAY_W      = 5;
  localparam int MAX_YEAR_W = 15;
  localparam int CENT_W     = 8;   // year / 100 for any 14-bit year
  localparam int DNUM_W     = 23;  // day number of any 14-bit year
  localparam int COUNT_W    = 22;
  localparam int DEF_MAX_YEAR = 9999;

  // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for every 14-bit x.
  localparam int DIV100_MUL   = 5243;
  localparam int DIV100_SHIFT = 19;
  localparam int PROD_W       = YEAR_W + 13;

  localparam logic [COUNT_W-1:0] OVERLAP_MAX = '1;

  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;

  typedef struct packed {
    logic              ok;
    logic [DNUM_W-1:0] dnum;
  } lane_res_t;

  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] r;
    unique case (m)
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] r;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/dpod_lane.sv =====
module dpod_lane #(
  parameter int MAX_YEAR = dpod_pkg::DEF_MAX_YEAR
) (
  input  logic                          clk,
  input  logic [dpod_pkg::YEAR_W-1:0]   year,
  input  logic [dpod_pkg::MONTH_W-1:0]  month,
  input  logic [dpod_pkg::DAY_W-1:0]    day,
  output dpod_pkg::lane_res_t           res
);

  localparam logic [dpod_pkg::MAX_YEAR_W-1:0] MaxYearV =
    dpod_pkg::MAX_YEAR_W'(MAX_YEAR);

  // Stage 1: year range check and the two divisions by 100.
  logic [dpod_pkg::YEAR_W-1:0]  y_r, p_r;
  logic [dpod_pkg::MONTH_W-1:0] m_r;
  logic [dpod_pkg::DAY_W-1:0]   d_r;
  logic [dpod_pkg::CENT_W-1:0]  qy_r, qp_r;
  logic                         yok_r;

  logic [dpod_pkg::YEAR_W-1:0]  p_nxt;
  logic [dpod_pkg::PROD_W-1:0]  prod_y, prod_p;

  assign p_nxt  = year - 1'b1;
  assign prod_y = dpod_pkg::PROD_W'(year) * dpod_pkg::PROD_W'(dpod_pkg::DIV100_MUL);
  assign prod_p = dpod_pkg::PROD_W'(p_nxt) * dpod_pkg::PROD_W'(dpod_pkg::DIV100_MUL);

  always_ff @(posedge clk) begin
    y_r   <= year;
    p_r   <= p_nxt;
    m_r   <= month;
    d_r   <= day;
    qy_r  <= dpod_pkg::CENT_W'(prod_y >> dpod_pkg::DIV100_SHIFT);
    qp_r  <= dpod_pkg::CENT_W'(prod_p >> dpod_pkg::DIV100_SHIFT);
    yok_r <= (year != '0) && (dpod_pkg::MAX_YEAR_W'(year) <= MaxYearV);
  end

  // Stage 2: leap rule, month and day check, day number.
  logic                          cent_year, leap, m_ok, d_ok;
  logic [dpod_pkg::DAY_W-1:0]    len;
  logic [dpod_pkg::DNUM_W-1:0]   dnum;
  dpod_pkg::lane_res_t           res_nxt, res_r;

  always_comb begin
    cent_year = (y_r == dpod_pkg::YEAR_W'(qy_r) * dpod_pkg::YEAR_W'(100));
    leap      = ((y_r[1:0] == 2'b00) && !cent_year) || (cent_year && (qy_r[1:0] == 2'b00));
    len       = dpod_pkg::month_len(m_r, leap);
    m_ok      = (m_r != '0) && (m_r <= dpod_pkg::DEC);
    d_ok      = (d_r != '0) && (d_r <= len);
    dnum      = dpod_pkg::DNUM_W'(p_r) * dpod_pkg::DNUM_W'(365)
              + dpod_pkg::DNUM_W'(p_r >> 2)
              - dpod_pkg::DNUM_W'(qp_r)
              + dpod_pkg::DNUM_W'(qp_r >> 2)
              + dpod_pkg::DNUM_W'(dpod_pkg::days_before(m_r))
              + dpod_pkg::DNUM_W'(leap && (m_r > dpod_pkg::FEB))
              + dpod_pkg::DNUM_W'(d_r)
              - dpod_pkg::DNUM_W'(1);
    res_nxt.ok   = yok_r && m_ok && d_ok;
    res_nxt.dnum = dnum;
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/core/dpod_merge.sv =====
module dpod_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid,
  input  dpod_pkg::lane_res_t           first_start,
  input  dpod_pkg::lane_res_t           first_end,
  input  dpod_pkg::lane_res_t           second_start,
  input  dpod_pkg::lane_res_t           second_end,
  output logic                          out_valid,
  output logic [dpod_pkg::COUNT_W-1:0]  out_overlap_days,
  output logic                          out_bad_date
);

  // Stage 1: later start, earlier end.
  logic                        v1_r, ok_r;
  logic [dpod_pkg::DNUM_W-1:0] lo_r, hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= valid;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= first_start.ok && first_end.ok && second_start.ok && second_end.ok;
    lo_r <= (first_start.dnum > second_start.dnum) ? first_start.dnum : second_start.dnum;
    hi_r <= (first_end.dnum < second_end.dnum) ? first_end.dnum : second_end.dnum;
  end

  // Stage 2: inclusive count, clamped to the output width.
  logic [dpod_pkg::DNUM_W:0]    span;
  logic [dpod_pkg::COUNT_W-1:0] cnt_nxt, cnt_r;
  logic                         bad_r, v2_r;

  always_comb begin
    span = (dpod_pkg::DNUM_W+1)'(hi_r) - (dpod_pkg::DNUM_W+1)'(lo_r)
         + (dpod_pkg::DNUM_W+1)'(1);
    if (!ok_r || (hi_r < lo_r)) begin
      cnt_nxt = '0;
    end else if (span > (dpod_pkg::DNUM_W+1)'(dpod_pkg::OVERLAP_MAX)) begin
      cnt_nxt = dpod_pkg::OVERLAP_MAX;
    end else begin
      cnt_nxt = dpod_pkg::COUNT_W'(span);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    bad_r <= !ok_r;
  end

  assign out_valid        = v2_r;
  assign out_overlap_days = cnt_r;
  assign out_bad_date     = bad_r;

endmodule

// ===== rtl/core/date_period_overlap_days.sv =====
// Channel  | Handshake              | Word
// ---------+------------------------+-----------------------------------------
// input    | start & !busy          | in_* : two periods, four y/m/d dates
// result   | out_valid, one cycle   | out_overlap_days, out_bad_date
//
// One word is taken every clock cycle; busy is always low.
// Each result takes its word through, in order: the date lanes register the
// divide by 100 and then the day number, and the merge stage registers the later
// start and earlier end and then the clamped count that drives the outputs.
// Reset clears only the valid pipeline; data registers are not reset.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module date_period_overlap_days #(
  parameter int MAX_YEAR = dpod_pkg::DEF_MAX_YEAR
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_first_start_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_first_start_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_first_start_day,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_first_end_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_first_end_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_first_end_day,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_second_start_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_second_start_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_second_start_day,
  input  logic [dpod_pkg::YEAR_W-1:0]   in_second_end_year,
  input  logic [dpod_pkg::MONTH_W-1:0]  in_second_end_month,
  input  logic [dpod_pkg::DAY_W-1:0]    in_second_end_day,
  output logic                          out_valid,
  output logic [dpod_pkg::COUNT_W-1:0]  out_overlap_days,
  output logic                          out_bad_date
);

  logic [1:0] vld_r, vld_nxt;
  dpod_pkg::lane_res_t fs_res, fe_res, ss_res, se_res;

  assign busy    = 1'b0;
  assign vld_nxt = {vld_r[0], start && !busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  dpod_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_fs (
    .clk   (clk),
    .year  (in_first_start_year),
    .month (in_first_start_month),
    .day   (in_first_start_day),
    .res   (fs_res)
  );

  dpod_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_fe (
    .clk   (clk),
    .year  (in_first_end_year),
    .month (in_first_end_month),
    .day   (in_first_end_day),
    .res   (fe_res)
  );

  dpod_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_ss (
    .clk   (clk),
    .year  (in_second_start_year),
    .month (in_second_start_month),
    .day   (in_second_start_day),
    .res   (ss_res)
  );

  dpod_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_se (
    .clk   (clk),
    .year  (in_second_end_year),
    .month (in_second_end_month),
    .day   (in_second_end_day),
    .res   (se_res)
  );

  dpod_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .valid            (vld_r[1]),
    .first_start      (fs_res),
    .first_end        (fe_res),
    .second_start     (ss_res),
    .second_end       (se_res),
    .out_valid        (out_valid),
    .out_overlap_days (out_overlap_days),
    .out_bad_date     (out_bad_date)
  );

endmodule
